// ===== rtl/core/sscp_pkg.sv =====
// Shared types and constants of the scrolling strip-chart plotter.
`default_nettype none
package sscp_pkg;

    localparam int LANES       = 4;
    localparam int SAMPLE_W    = 16;
    localparam int READ_COL_W  = 8;
    localparam int COL_BITS_W  = 64;
    localparam int FLAGS_W     = 4;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 80;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 3;
    localparam int COUNT_W     = 16;
    localparam int PROD_W      = 34;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_STEPS_PER_SCROLL  = 3'd0,
        CFG_SCROLLS_PER_FRAME = 3'd1,
        CFG_ACTIVE_CHANNELS   = 3'd2,
        CFG_CHANNEL_MINIMUMS  = 3'd3,
        CFG_CHANNEL_SCALES    = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic underflow;
        logic overflow;
    } lane_flags_t;

endpackage
`default_nettype wire

// ===== rtl/core/sscp_ram.sv =====
// Generic single-port RAM with registered read.
`default_nettype none
module sscp_ram #(
    parameter int DATA_W = 64,
    parameter int DEPTH  = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [DATA_W-1:0]        wdata,
    output logic      [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata <= mem[addr];
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/sscp_lane.sv =====
// One channel lane: offset and scale a sample, then map it to a row pixel and range flags.
`default_nettype none
module sscp_lane #(
    parameter int HEIGHT = 64
) (
    input  wire logic                                 aclk,
    input  wire logic                                 load,
    input  wire logic        [sscp_pkg::SAMPLE_W-1:0] sample,
    input  wire logic        [sscp_pkg::SAMPLE_W-1:0] minimum,
    input  wire logic        [sscp_pkg::SAMPLE_W-1:0] scale,
    input  wire logic                                 active,
    output sscp_pkg::lane_flags_t                     flags,
    output logic             [HEIGHT-1:0]             pixels
);

    localparam int ROW_W = $clog2(HEIGHT);

    logic signed [sscp_pkg::SAMPLE_W:0]     diff;
    logic signed [sscp_pkg::SAMPLE_W:0]     scale_s;
    logic signed [sscp_pkg::PROD_W-1:0]     prod_next;
    logic signed [sscp_pkg::PROD_W-1:0]     prod_reg;
    logic                                   active_reg;
    logic        [sscp_pkg::PROD_W:0]       rounded;
    logic                                   below;
    logic                                   above;
    logic        [ROW_W-1:0]                row;

    assign diff      = {sample[sscp_pkg::SAMPLE_W-1], sample}
                     - {minimum[sscp_pkg::SAMPLE_W-1], minimum};
    assign scale_s   = {1'b0, scale};
    assign prod_next = diff * scale_s;

    always_ff @(posedge aclk) begin
        if (load) begin
            prod_reg   <= prod_next;
            active_reg <= active;
        end
    end

    assign rounded = {prod_reg[sscp_pkg::PROD_W-1], prod_reg}
                   + (sscp_pkg::PROD_W+1)'(128);
    assign below   = rounded[sscp_pkg::PROD_W];
    assign above   = !below
                   && (rounded[sscp_pkg::PROD_W-1:8] >= (sscp_pkg::PROD_W-8)'(HEIGHT));
    assign row     = ROW_W'(HEIGHT - 1) - rounded[ROW_W+7:8];

    assign flags.underflow = active_reg && below;
    assign flags.overflow  = active_reg && above;
    assign pixels = (active_reg && !below && !above)
                  ? (HEIGHT'(1) << row) : '0;

endmodule
`default_nettype wire

// ===== rtl/core/scrolling_strip_chart_plotter_unit.sv =====
// Top level of the scrolling strip-chart plotter: counters, column ring and result stage.
// A request is accepted, mapped and written or read in the column RAM, and its result is
// registered in stage 1, stage 2 and the output register; one request per cycle is sustained
// while m_tready holds, set by the single column RAM port and one multiplier per channel lane.
// Reset clears the scroll, frame and ring pointers and a fill count; columns that were
// never cleared since reset read as zero through the fill count, so no clearing pass runs.
`default_nettype none
module scrolling_strip_chart_plotter_unit #(
    parameter int WIDTH    = 256,
    parameter int HEIGHT   = 64,
    parameter int CHANNELS = 4
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 cfg_wr_en,
    input  wire logic [sscp_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [sscp_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // sample_a, sample_b, sample_c, sample_d, read_column
    input  wire logic [sscp_pkg::IN_TDATA_W-1:0]      s_tdata,
    // action
    input  wire logic                                 s_tuser,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // frame_ready, column_bits, underflow_flags, overflow_flags, zero pad
    output logic      [sscp_pkg::OUT_TDATA_W-1:0]     m_tdata
);

    localparam int AW = $clog2(WIDTH);
    localparam int FW = $clog2(WIDTH + 1);
    localparam int SW = AW + 9;
    localparam int CW = sscp_pkg::COUNT_W;

    // configuration
    logic [CW-1:0]                     steps_reg;
    logic [CW-1:0]                     spf_reg;
    logic [2:0]                        active_reg;
    logic [sscp_pkg::CFG_DATA_W-1:0]   mins_reg;
    logic [sscp_pkg::CFG_DATA_W-1:0]   scales_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            steps_reg  <= CW'(1);
            spf_reg    <= CW'(1);
            active_reg <= 3'd1;
            mins_reg   <= '0;
            scales_reg <= 64'h0100_0100_0100_0100;
        end else if (cfg_wr_en) begin
            unique case (sscp_pkg::cfg_index_t'(cfg_index))
                sscp_pkg::CFG_STEPS_PER_SCROLL:  steps_reg  <= cfg_data[CW-1:0];
                sscp_pkg::CFG_SCROLLS_PER_FRAME: spf_reg    <= cfg_data[CW-1:0];
                sscp_pkg::CFG_ACTIVE_CHANNELS:   active_reg <= cfg_data[2:0];
                sscp_pkg::CFG_CHANNEL_MINIMUMS:  mins_reg   <= cfg_data;
                sscp_pkg::CFG_CHANNEL_SCALES:    scales_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // pipeline handshake
    logic s1_valid_reg, s2_valid_reg, out_valid_reg;
    logic s2_move, s1_move, accept;

    assign s2_move  = !out_valid_reg || m_tready;
    assign s1_move  = s1_valid_reg && (!s2_valid_reg || s2_move);
    assign s_tready = !s1_valid_reg || !s2_valid_reg || s2_move;
    assign accept   = s_tvalid && s_tready;

    // ring and counters
    logic [AW-1:0] ptr_reg, ptr_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [CW-1:0] scroll_reg, scroll_next;
    logic [CW-1:0] frame_reg, frame_next;
    logic          scroll_now;
    logic          frame_ready_now;
    logic [AW-1:0] newest;
    logic [CW-1:0] scroll_inc;
    logic [CW-1:0] frame_inc;
    logic          is_read;

    assign is_read    = s_tuser;
    assign scroll_now = (scroll_reg == '0);
    assign scroll_inc = scroll_reg + CW'(1);
    assign frame_inc  = frame_reg + CW'(1);

    always_comb begin
        ptr_next        = ptr_reg;
        fill_next       = fill_reg;
        scroll_next     = scroll_reg;
        frame_next      = frame_reg;
        frame_ready_now = 1'b0;
        newest          = (ptr_reg == '0) ? AW'(WIDTH - 1) : ptr_reg - AW'(1);
        if (scroll_now) begin
            newest = ptr_reg;
        end
        if (accept && !is_read) begin
            if (scroll_now) begin
                ptr_next = (ptr_reg == AW'(WIDTH - 1)) ? '0 : ptr_reg + AW'(1);
                if (fill_reg != FW'(WIDTH)) begin
                    fill_next = fill_reg + FW'(1);
                end
            end
            if (scroll_inc >= steps_reg) begin
                scroll_next = '0;
                if (frame_inc >= spf_reg) begin
                    frame_next      = '0;
                    frame_ready_now = 1'b1;
                end else begin
                    frame_next = frame_inc;
                end
            end else begin
                scroll_next = scroll_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg    <= '0;
            fill_reg   <= '0;
            scroll_reg <= '0;
            frame_reg  <= '0;
        end else begin
            ptr_reg    <= ptr_next;
            fill_reg   <= fill_next;
            scroll_reg <= scroll_next;
            frame_reg  <= frame_next;
        end
    end

    // read address into the ring
    logic [SW-1:0] rc_ext, sum, sum_mod;
    logic          rd_ok;

    assign rc_ext  = SW'(s_tdata[71:64]);
    assign sum     = SW'(ptr_reg) + rc_ext;
    assign sum_mod = (sum >= SW'(WIDTH)) ? sum - SW'(WIDTH) : sum;
    assign rd_ok   = (rc_ext < SW'(WIDTH)) && (sum_mod < SW'(fill_reg));

    // stage 1
    logic          s1_read_reg, s1_ok_reg, s1_scroll_reg, s1_frame_reg;
    logic [AW-1:0] s1_addr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_move) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_read_reg   <= is_read;
            s1_ok_reg     <= rd_ok;
            s1_scroll_reg <= scroll_now;
            s1_frame_reg  <= frame_ready_now;
            s1_addr_reg   <= is_read ? sum_mod[AW-1:0] : newest;
        end
    end

    // channel lanes
    sscp_pkg::lane_flags_t       lane_flags [sscp_pkg::LANES];
    logic [HEIGHT-1:0]           lane_pix   [sscp_pkg::LANES];
    logic [sscp_pkg::FLAGS_W-1:0] under_now, over_now;
    logic [HEIGHT-1:0]           pix_all;

    for (genvar c = 0; c < sscp_pkg::LANES; c++) begin : g_lane
        if (c < CHANNELS) begin : g_on
            sscp_lane #(
                .HEIGHT (HEIGHT)
            ) u_lane (
                .aclk    (aclk),
                .load    (accept),
                .sample  (s_tdata[16*c +: 16]),
                .minimum (mins_reg[16*c +: 16]),
                .scale   (scales_reg[16*c +: 16]),
                .active  (3'(c) < active_reg),
                .flags   (lane_flags[c]),
                .pixels  (lane_pix[c])
            );
        end else begin : g_off
            assign lane_flags[c] = '0;
            assign lane_pix[c]   = '0;
        end
        assign under_now[c] = lane_flags[c].underflow;
        assign over_now[c]  = lane_flags[c].overflow;
    end

    always_comb begin
        pix_all = '0;
        for (int c = 0; c < sscp_pkg::LANES; c++) begin
            pix_all = pix_all | lane_pix[c];
        end
    end

    // newest column forwarding and RAM write-through
    logic [HEIGHT-1:0] cur_col_reg;
    logic [HEIGHT-1:0] col_new;
    logic [HEIGHT-1:0] rdata;
    logic              plot_move;

    assign plot_move = s1_move && !s1_read_reg;
    assign col_new   = (s1_scroll_reg ? '0 : cur_col_reg) | pix_all;

    always_ff @(posedge aclk) begin
        if (plot_move) begin
            cur_col_reg <= col_new;
        end
    end

    sscp_ram #(
        .DATA_W (HEIGHT),
        .DEPTH  (WIDTH)
    ) u_ram (
        .aclk  (aclk),
        .en    (s1_move),
        .we    (plot_move),
        .addr  (s1_addr_reg),
        .wdata (col_new),
        .rdata (rdata)
    );

    // stage 2
    logic                         s2_read_reg, s2_ok_reg, s2_frame_reg;
    logic [sscp_pkg::FLAGS_W-1:0] s2_under_reg, s2_over_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s1_move) begin
            s2_valid_reg <= 1'b1;
        end else if (s2_move) begin
            s2_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_move) begin
            s2_read_reg  <= s1_read_reg;
            s2_ok_reg    <= s1_read_reg && s1_ok_reg;
            s2_frame_reg <= !s1_read_reg && s1_frame_reg;
            s2_under_reg <= s1_read_reg ? '0 : under_now;
            s2_over_reg  <= s1_read_reg ? '0 : over_now;
        end
    end

    // output register
    logic [sscp_pkg::COL_BITS_W-1:0]  bits_now;
    logic [sscp_pkg::OUT_TDATA_W-1:0] out_data_reg;

    assign bits_now = (s2_read_reg && s2_ok_reg)
                    ? sscp_pkg::COL_BITS_W'(rdata) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s2_valid_reg && s2_move) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_valid_reg && s2_move) begin
            out_data_reg <= {7'd0, s2_over_reg, s2_under_reg, bits_now, s2_frame_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
`default_nettype wire
